// ===== rtl/race_start_light_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// Race start light sequencer assertion macros
// Shared property macros for the checker, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef RACE_START_LIGHT_SEQUENCER_ASSERT_SVH
`define RACE_START_LIGHT_SEQUENCER_ASSERT_SVH

// Condition that must hold in the same cycle
`define RSLS_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle
`define RSLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rsls_pkg.sv =====
// ----------------------------------------------------------------------------
// Race start light sequencer package
// Types, codes, register map and helpers for the start light sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsls_pkg;

  // Default number of red lamps
  localparam int unsigned LAMPS_DEFAULT = 5;

  // Field widths
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned CNT_W   = 24;
  localparam int unsigned CODE_W  = 3;
  localparam int unsigned LAMP_W  = 3;
  localparam int unsigned IN_DW   = 32;
  localparam int unsigned OUT_DW  = 16;
  localparam int unsigned APB_AW  = 5;
  localparam int unsigned APB_DW  = 32;

  // Register reset values
  localparam logic [MS_W-1:0]  GAP_MIN_RST  = 16'd800;
  localparam logic [MS_W-1:0]  GAP_MAX_RST  = 16'd1200;
  localparam logic [MS_W-1:0]  HOLD_MIN_RST = 16'd200;
  localparam logic [MS_W-1:0]  HOLD_MAX_RST = 16'd3000;
  localparam logic [CNT_W-1:0] SC_RST       = 24'd30000;
  localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};

  // Register indexes (word address)
  typedef enum logic [2:0] {
    REG_GAP_MIN  = 3'd0,
    REG_GAP_MAX  = 3'd1,
    REG_HOLD_MIN = 3'd2,
    REG_HOLD_MAX = 3'd3,
    REG_SC_MS    = 3'd4
  } reg_idx_e;

  // Command codes
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 3'd0,
    MODE_START  = 3'd1,
    MODE_DEPLOY = 3'd2,
    MODE_STOP   = 3'd3,
    MODE_RESET  = 3'd4
  } mode_e;

  // Phase codes as reported on the output
  typedef enum logic [CODE_W-1:0] {
    CODE_WAIT  = 3'd0,
    CODE_SEQ   = 3'd1,
    CODE_RACE  = 3'd2,
    CODE_SC    = 3'd3,
    CODE_STOP  = 3'd4
  } phase_code_e;

  // Phase state, one-hot
  typedef enum logic [4:0] {
    PH_WAIT = 5'b00001,
    PH_SEQ  = 5'b00010,
    PH_RACE = 5'b00100,
    PH_SC   = 5'b01000,
    PH_STOP = 5'b10000
  } phase_e;

  // Clamp a draw into [lo, hi_excl-1]; an empty range gives lo
  function automatic logic [MS_W-1:0] clamp_draw(input logic [MS_W-1:0] draw,
                                                 input logic [MS_W-1:0] lo,
                                                 input logic [MS_W-1:0] hi_excl);
    logic [MS_W-1:0] hi;
    hi = (hi_excl > lo) ? hi_excl - 1'b1 : lo;
    if (draw < lo) begin
      return lo;
    end else if (draw > hi) begin
      return hi;
    end
    return draw;
  endfunction

  // One-hot phase to output code
  function automatic phase_code_e phase_code(input phase_e ph);
    phase_code_e code;
    unique case (ph)
      PH_WAIT: code = CODE_WAIT;
      PH_SEQ:  code = CODE_SEQ;
      PH_RACE: code = CODE_RACE;
      PH_SC:   code = CODE_SC;
      PH_STOP: code = CODE_STOP;
      default: code = CODE_WAIT;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/race_start_light_sequencer.sv =====
// ----------------------------------------------------------------------------
// Race start light sequencer
// Steps a start-light phase machine by one command or 1 ms tick per
// transaction and reports phase, lamp count and flags for each one.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                                   Role
// s_axis    in   tvalid/tready/tdata[31:0]/tuser[2:0]      commands and ticks
// m_axis    out  tvalid/tready/tdata[15:0]                 phase and flags
// apb       in   psel/penable/pwrite/paddr[4:0]/pwdata     timing registers
//
// One transaction per cycle while m_axis_tready is high; each passes the input
// register, then its phase update lands in the output register with state.
// The output register and input register form a two-entry queue, so a new
// transaction is taken while a result waits for m_axis_tready.
// Async rst_ni clears valid flags and phase state and resets the registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module race_start_light_sequencer #(
  parameter int unsigned Lamps = rsls_pkg::LAMPS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Command stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] gap_draw, [31:16] hold_draw
  input  logic [rsls_pkg::IN_DW-1:0]    s_axis_tdata,
  // [2:0] mode
  input  logic [rsls_pkg::MODE_W-1:0]   s_axis_tuser,
  // Status stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] phase_code, [5:3] red_lit, [6] lights_out, [7] is_waiting,
  // [8] can_deploy, [15:9] zero
  output logic [rsls_pkg::OUT_DW-1:0]   m_axis_tdata,
  // Register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rsls_pkg::APB_AW-1:0]   paddr,
  input  logic [rsls_pkg::APB_DW-1:0]   pwdata,
  output logic [rsls_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam logic [rsls_pkg::LAMP_W-1:0] LampsW = rsls_pkg::LAMP_W'(Lamps);

  // Configuration registers
  logic [rsls_pkg::MS_W-1:0]  gap_min_q, gap_max_q, hold_min_q, hold_max_q;
  logic [rsls_pkg::CNT_W-1:0] sc_ms_q;
  logic                       cfg_wr;
  logic [2:0]                 cfg_idx;

  // Input register
  logic                        in_valid_q;
  logic [rsls_pkg::MODE_W-1:0] in_mode_q;
  logic [rsls_pkg::MS_W-1:0]   in_gap_q, in_hold_q;

  // Sequencer state
  rsls_pkg::phase_e            phase_q, phase_d;
  logic [rsls_pkg::LAMP_W-1:0] lamp_q, lamp_d;
  logic [rsls_pkg::CNT_W-1:0]  elapsed_q, elapsed_d;
  logic [rsls_pkg::MS_W-1:0]   hold_q, hold_d;
  logic                        pulse_d;

  // Output register
  logic                        out_valid_q;
  logic [rsls_pkg::OUT_DW-1:0] out_data_q, out_data_d;

  // Datapath helpers
  logic                        out_free, step;
  logic [rsls_pkg::CNT_W-1:0]  elapsed_inc;
  logic [rsls_pkg::MS_W-1:0]   gap_lim, hold_lim;
  logic [rsls_pkg::LAMP_W-1:0] lamp_inc;
  rsls_pkg::phase_code_e       code_d;

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_min_q  <= rsls_pkg::GAP_MIN_RST;
      gap_max_q  <= rsls_pkg::GAP_MAX_RST;
      hold_min_q <= rsls_pkg::HOLD_MIN_RST;
      hold_max_q <= rsls_pkg::HOLD_MAX_RST;
      sc_ms_q    <= rsls_pkg::SC_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rsls_pkg::REG_GAP_MIN:  gap_min_q  <= pwdata[rsls_pkg::MS_W-1:0];
        rsls_pkg::REG_GAP_MAX:  gap_max_q  <= pwdata[rsls_pkg::MS_W-1:0];
        rsls_pkg::REG_HOLD_MIN: hold_min_q <= pwdata[rsls_pkg::MS_W-1:0];
        rsls_pkg::REG_HOLD_MAX: hold_max_q <= pwdata[rsls_pkg::MS_W-1:0];
        rsls_pkg::REG_SC_MS:    sc_ms_q    <= pwdata[rsls_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      rsls_pkg::REG_GAP_MIN:  prdata = rsls_pkg::APB_DW'(gap_min_q);
      rsls_pkg::REG_GAP_MAX:  prdata = rsls_pkg::APB_DW'(gap_max_q);
      rsls_pkg::REG_HOLD_MIN: prdata = rsls_pkg::APB_DW'(hold_min_q);
      rsls_pkg::REG_HOLD_MAX: prdata = rsls_pkg::APB_DW'(hold_max_q);
      rsls_pkg::REG_SC_MS:    prdata = rsls_pkg::APB_DW'(sc_ms_q);
      default:                prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign step          = in_valid_q & out_free;
  assign s_axis_tready = ~in_valid_q | out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mode_q <= s_axis_tuser;
      in_gap_q  <= s_axis_tdata[15:0];
      in_hold_q <= s_axis_tdata[31:16];
    end
  end

  // ---------------- phase update ----------------
  assign elapsed_inc = (elapsed_q == rsls_pkg::CNT_MAX) ? elapsed_q : elapsed_q + 1'b1;
  assign gap_lim     = rsls_pkg::clamp_draw(in_gap_q, gap_min_q, gap_max_q);
  assign hold_lim    = rsls_pkg::clamp_draw(in_hold_q, hold_min_q, hold_max_q);
  assign lamp_inc    = lamp_q + 1'b1;

  always_comb begin
    phase_d   = phase_q;
    lamp_d    = lamp_q;
    elapsed_d = elapsed_q;
    hold_d    = hold_q;
    pulse_d   = 1'b0;
    unique case (in_mode_q)
      rsls_pkg::MODE_TICK: begin
        if (phase_q == rsls_pkg::PH_SEQ) begin
          elapsed_d = elapsed_inc;
          if (lamp_q < LampsW) begin
            // next lamp once the gap has run out
            if (elapsed_inc >= rsls_pkg::CNT_W'(gap_lim)) begin
              lamp_d    = lamp_inc;
              elapsed_d = '0;
              if (lamp_inc == LampsW) begin
                hold_d = hold_lim;
              end
            end
          end else if (elapsed_inc >= rsls_pkg::CNT_W'(hold_q)) begin
            phase_d = rsls_pkg::PH_RACE;
            pulse_d = 1'b1;
          end
        end else if (phase_q == rsls_pkg::PH_SC) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= sc_ms_q) begin
            phase_d = rsls_pkg::PH_RACE;
          end
        end
      end
      rsls_pkg::MODE_START: begin
        phase_d   = rsls_pkg::PH_SEQ;
        lamp_d    = '0;
        elapsed_d = '0;
      end
      rsls_pkg::MODE_DEPLOY: begin
        phase_d   = rsls_pkg::PH_SC;
        elapsed_d = '0;
      end
      rsls_pkg::MODE_STOP: begin
        phase_d = rsls_pkg::PH_STOP;
      end
      rsls_pkg::MODE_RESET: begin
        phase_d = rsls_pkg::PH_WAIT;
        lamp_d  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rsls_pkg::PH_WAIT;
      lamp_q    <= '0;
      elapsed_q <= '0;
      hold_q    <= '0;
    end else if (step) begin
      phase_q   <= phase_d;
      lamp_q    <= lamp_d;
      elapsed_q <= elapsed_d;
      hold_q    <= hold_d;
    end
  end

  // ---------------- result register ----------------
  assign code_d = rsls_pkg::phase_code(phase_d);

  always_comb begin
    out_data_d      = '0;
    out_data_d[2:0] = code_d;
    out_data_d[5:3] = lamp_d;
    out_data_d[6]   = pulse_d;
    out_data_d[7]   = (phase_d == rsls_pkg::PH_WAIT);
    out_data_d[8]   = (phase_d == rsls_pkg::PH_WAIT) | (phase_d == rsls_pkg::PH_RACE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/rsls_checker.sv =====
// ----------------------------------------------------------------------------
// Race start light sequencer checker
// Port-level properties of the status stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "race_start_light_sequencer_assert.svh"

module rsls_checker #(
  parameter int unsigned Lamps = rsls_pkg::LAMPS_DEFAULT
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [rsls_pkg::OUT_DW-1:0] m_axis_tdata
);

  localparam logic [rsls_pkg::LAMP_W-1:0] LampsW = rsls_pkg::LAMP_W'(Lamps);

  logic [2:0] code;
  logic [2:0] red;
  logic       lout, waiting, deploy;

  assign code    = m_axis_tdata[2:0];
  assign red     = m_axis_tdata[5:3];
  assign lout    = m_axis_tdata[6];
  assign waiting = m_axis_tdata[7];
  assign deploy  = m_axis_tdata[8];

  // A stalled status transaction stays put
  `RSLS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata), "status changed while stalled")

  // Lights out only with all lamps lit and the race on
  `RSLS_ASSERT_NOW(a_lights_out, !m_axis_tvalid || !lout ||
                   (code == rsls_pkg::CODE_RACE && red == LampsW), "bad lights out")

  // Lamp count never passes the lamp total
  `RSLS_ASSERT_NOW(a_lamp_range, !m_axis_tvalid || red <= LampsW, "lamp count overflow")

  // Flags agree with the phase code
  `RSLS_ASSERT_NOW(a_flags, !m_axis_tvalid ||
                   ((waiting == (code == rsls_pkg::CODE_WAIT)) &&
                    (deploy == (code == rsls_pkg::CODE_WAIT || code == rsls_pkg::CODE_RACE))),
                   "flags disagree with phase")

endmodule

bind race_start_light_sequencer rsls_checker #(.Lamps(Lamps)) u_rsls_checker (.*);
